// ===== sv/square_voice_with_adsr_assert.svh =====
// Assertion macros shared by the voice RTL.
// Each macro expands to one labeled concurrent assertion with an active-low
// reset disable.
`ifndef SQUARE_VOICE_WITH_ADSR_ASSERT_SVH
`define SQUARE_VOICE_WITH_ADSR_ASSERT_SVH

// Same-cycle implication.
`define SVADSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SVADSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/svadsr_pkg.sv =====
`timescale 1ns / 1ps

package svadsr_pkg;

  // Envelope levels, Q1.15
  localparam logic [16:0] ONE_Q15     = 17'd32768;
  localparam logic [16:0] SUSTAIN_Q15 = 17'd26214;
  localparam logic [16:0] DECAY_K     = ONE_Q15 - SUSTAIN_Q15;

  // Ramp quotients stay below 2^15
  localparam int Q_W = 15;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_ATTACK   = 3'd1,
    REG_DECAY    = 3'd2,
    REG_RELEASE  = 3'd3,
    REG_VELOCITY = 3'd4
  } reg_idx_t;

  // Configuration register values
  typedef struct packed {
    logic [15:0] period_len;
    logic [15:0] attack_len;
    logic [15:0] decay_len;
    logic [15:0] release_len;
    logic [15:0] note_velocity;
  } cfg_regs_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/svadsr_cfg.sv =====
`timescale 1ns / 1ps

module svadsr_cfg import svadsr_pkg::*; #(
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_regs_t   regs
);

  localparam logic [15:0] LEN_MASK =
    (LEN_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << LEN_BITS) - 32'd1);

  cfg_regs_t regs_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign regs   = regs_r;

  // Write registers, lengths keep their low bits only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.period_len    <= 16'd100;
      regs_r.attack_len    <= 16'd480 & LEN_MASK;
      regs_r.decay_len     <= 16'd1440 & LEN_MASK;
      regs_r.release_len   <= 16'd2400 & LEN_MASK;
      regs_r.note_velocity <= 16'hFFFF;
    end else if (wr_en) begin
      case (idx)
        REG_PERIOD:   regs_r.period_len    <= pwdata[15:0];
        REG_ATTACK:   regs_r.attack_len    <= pwdata[15:0] & LEN_MASK;
        REG_DECAY:    regs_r.decay_len     <= pwdata[15:0] & LEN_MASK;
        REG_RELEASE:  regs_r.release_len   <= pwdata[15:0] & LEN_MASK;
        REG_VELOCITY: regs_r.note_velocity <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_PERIOD:   prdata = {16'd0, regs_r.period_len};
      REG_ATTACK:   prdata = {16'd0, regs_r.attack_len};
      REG_DECAY:    prdata = {16'd0, regs_r.decay_len};
      REG_RELEASE:  prdata = {16'd0, regs_r.release_len};
      REG_VELOCITY: prdata = {16'd0, regs_r.note_velocity};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/svadsr_div.sv =====
`timescale 1ns / 1ps

module svadsr_div import svadsr_pkg::*; #(
  parameter int LW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LW+Q_W-1:0] num,
  input  logic [LW-1:0]     den,
  output logic [Q_W-1:0]    quot,
  output div_stat_t         stat
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [LW-1:0]    rem_r;
  logic [Q_W-1:0]   nlo_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [LW:0]      trial;
  logic             fits;
  logic [LW:0]      diff;

  // One restoring step: bring down the next numerator bit
  assign trial = {rem_r, nlo_r[Q_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[LW+Q_W-1:Q_W];
      nlo_r <= num[Q_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[LW-1:0] : trial[LW-1:0];
      nlo_r <= {nlo_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], fits};
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== sv/square_voice_with_adsr.sv =====
`timescale 1ns / 1ps
`include "square_voice_with_adsr_assert.svh"

// One square-wave voice with a linear attack/decay/sustain/release envelope.
// A note-off item is taken straight from idle and gives no result. A sample
// tick runs through a small sequencer: compare, select, gain, mix and done when
// the envelope sits at sustain or zero, with a multiply and the 15-step
// restoring divider that works out the ramp level added while a ramp is active;
// one multiplier is shared between the ramp numerator and the velocity gain.
// The next item is taken once the voice is back in idle, even while the
// previous result still waits at the output.

module square_voice_with_adsr import svadsr_pkg::*; #(
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_mix_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_mix_out,
  output logic        out_exhausted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW = (LEN_BITS < 16) ? LEN_BITS : 16;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_CMP_AD  = 11'b000_0000_0010,
    ST_CMP_REL = 11'b000_0000_0100,
    ST_CMP_END = 11'b000_0000_1000,
    ST_SELECT  = 11'b000_0001_0000,
    ST_MUL     = 11'b000_0010_0000,
    ST_DSTART  = 11'b000_0100_0000,
    ST_DIV     = 11'b000_1000_0000,
    ST_GAIN    = 11'b001_0000_0000,
    ST_MIX     = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_t;

  cfg_regs_t regs;
  div_stat_t div_stat;

  state_t   state_r, state_nxt;
  logic [LW-1:0] len_a, len_d, len_r;

  // Voice state
  logic [15:0] phase_r;
  logic [31:0] samples_r;
  logic        released_r;
  logic [31:0] rel_start_r;

  // Per-item working registers
  logic [15:0]       mix_r;
  logic              lt_a_r, lt_ad_r, e_ge_r_r, done_r, decay_sel_r;
  logic [31:0]       e_r;
  logic [LW-1:0]     x_r, den_r;
  logic [16:0]       k_r;
  logic [15:0]       env_r;
  logic [LW+Q_W-1:0] num_r;
  logic [Q_W-1:0]    mag_r;
  logic [15:0]       res_r;
  logic [Q_W-1:0]    quot;

  logic        out_valid_r;
  logic [15:0] out_mix_r;
  logic        out_exh_r;

  // Shared multiplier
  logic [15:0] mul_a;
  logic [16:0] mul_b;
  logic [32:0] mul_p;

  logic        accept;
  logic        out_free;
  logic [31:0] s_minus_a;
  logic [32:0] rel_end;
  logic [17:0] mix_ext, voice_ext, sum;
  logic        wave_pos;
  logic [16:0] phase_inc;

  svadsr_cfg #(.LEN_BITS(LEN_BITS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  svadsr_div #(.LW(LW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DSTART),
    .num   (num_r),
    .den   (den_r),
    .quot  (quot),
    .stat  (div_stat)
  );

  assign len_a = regs.attack_len[LW-1:0];
  assign len_d = regs.decay_len[LW-1:0];
  assign len_r = regs.release_len[LW-1:0];

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign s_minus_a = samples_r - 32'(len_a);
  assign rel_end   = {1'b0, rel_start_r} + 33'(len_r);

  // Multiplier operands: ramp numerator, then velocity gain
  always_comb begin
    if (state_r == ST_GAIN) begin
      mul_a = env_r;
      mul_b = {1'b0, regs.note_velocity};
    end else begin
      mul_a = 16'(x_r);
      mul_b = k_r;
    end
  end
  assign mul_p = 33'(mul_a) * 33'(mul_b);

  // Signed mix; saturation is applied in ST_MIX
  assign wave_pos  = phase_r > {1'b0, regs.period_len[15:1]};
  assign mix_ext   = {{2{mix_r[15]}}, mix_r};
  assign voice_ext = {3'b000, mag_r};
  assign sum       = wave_pos ? mix_ext + voice_ext : mix_ext - voice_ext;

  assign phase_inc = {1'b0, phase_r} + 17'd1;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept && !in_kind) state_nxt = ST_CMP_AD;
      ST_CMP_AD:  state_nxt = ST_CMP_REL;
      ST_CMP_REL: state_nxt = ST_CMP_END;
      ST_CMP_END: state_nxt = ST_SELECT;
      ST_SELECT: begin
        if (lt_a_r || lt_ad_r) begin
          state_nxt = ST_MUL;
        end else if (released_r && len_r != '0 && !e_ge_r_r) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_GAIN;
        end
      end
      ST_MUL:     state_nxt = ST_DSTART;
      ST_DSTART:  state_nxt = ST_DIV;
      ST_DIV:     if (div_stat.done) state_nxt = ST_GAIN;
      ST_GAIN:    state_nxt = ST_MIX;
      ST_MIX:     state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Envelope stage evaluation, ramp setup, gain and saturated mix
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        mix_r <= in_mix_in;
      end
      ST_CMP_AD: begin
        lt_a_r  <= samples_r < 32'(len_a);
        lt_ad_r <= samples_r < (32'(len_a) + 32'(len_d));
      end
      ST_CMP_REL: begin
        e_r <= (samples_r >= rel_start_r) ? samples_r - rel_start_r : 32'd0;
      end
      ST_CMP_END: begin
        e_ge_r_r <= e_r >= 32'(len_r);
        done_r   <= released_r && ({1'b0, samples_r} >= rel_end);
      end
      ST_SELECT: begin
        decay_sel_r <= 1'b0;
        if (lt_a_r) begin
          x_r   <= samples_r[LW-1:0];
          k_r   <= ONE_Q15;
          den_r <= len_a;
        end else if (lt_ad_r) begin
          x_r         <= s_minus_a[LW-1:0];
          k_r         <= DECAY_K;
          den_r       <= len_d;
          decay_sel_r <= 1'b1;
        end else if (released_r) begin
          x_r   <= len_r - e_r[LW-1:0];
          k_r   <= SUSTAIN_Q15;
          den_r <= len_r;
          env_r <= 16'd0;
        end else begin
          env_r <= SUSTAIN_Q15[15:0];
        end
      end
      ST_MUL: begin
        num_r <= mul_p[LW+Q_W-1:0];
      end
      ST_DIV: begin
        if (div_stat.done) begin
          env_r <= decay_sel_r ? 16'(ONE_Q15 - 17'(quot)) : 16'(quot);
        end
      end
      ST_GAIN: begin
        mag_r <= mul_p[30:16];
      end
      ST_MIX: begin
        if ($signed(sum) > $signed(18'sd32767)) begin
          res_r <= 16'h7FFF;
        end else if ($signed(sum) < -$signed(18'sd32768)) begin
          res_r <= 16'h8000;
        end else begin
          res_r <= sum[15:0];
        end
      end
      default: ;
    endcase
  end

  // Voice state: note off, and advance after each tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 16'd0;
      samples_r   <= 32'd0;
      released_r  <= 1'b0;
      rel_start_r <= 32'd0;
    end else if (accept && in_kind) begin
      released_r  <= 1'b1;
      rel_start_r <= samples_r;
    end else if (state_r == ST_DONE && out_free) begin
      if (regs.period_len <= 16'd1) begin
        phase_r <= 16'd0;
      end else if (phase_inc >= {1'b0, regs.period_len}) begin
        phase_r <= 16'(phase_inc - {1'b0, regs.period_len});
      end else begin
        phase_r <= phase_inc[15:0];
      end
      if (samples_r != 32'hFFFF_FFFF) begin
        samples_r <= samples_r + 32'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_mix_r <= res_r;
      out_exh_r <= done_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mix_out   = out_mix_r;
  assign out_exhausted = out_exh_r;

  `SVADSR_ASSERT_NOW(a_div_den_nonzero, clk, rst_n, (state_r == ST_DSTART),
    (den_r != '0 && !div_stat.busy), "divider started with zero divisor or while busy")
  `SVADSR_ASSERT_NOW(a_div_done_in_wait, clk, rst_n, div_stat.done,
    (state_r == ST_DIV), "divider finished outside its wait state")
  `SVADSR_ASSERT_NEXT(a_note_off_release, clk, rst_n, (accept && in_kind),
    (released_r && rel_start_r == $past(samples_r)), "note off not recorded")
  `SVADSR_ASSERT_NEXT(a_tick_starts, clk, rst_n, (accept && !in_kind),
    (state_r == ST_CMP_AD), "tick item did not start evaluation")

endmodule
